// File: hdl/assert_macros.svh
// Assertion macros used by the checksum engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: hdl/mmce_pkg.sv
// Types, constants and CRC step functions for the multi-mode checksum engine.
`timescale 1ns / 1ps

package mmce_pkg;

	localparam logic [2:0] MODE_NONE     = 3'd0;
	localparam logic [2:0] MODE_CRC_REFL = 3'd1;
	localparam logic [2:0] MODE_WORD_SUM = 3'd2;
	localparam logic [2:0] MODE_BYTE_SUM = 3'd3;
	localparam logic [2:0] MODE_CRC_SKIP = 3'd4;

	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_CRC_POLY  = 2'd1;
	localparam logic [1:0] REG_LE_WORDS  = 2'd2;
	localparam logic [1:0] REG_SKIP_ADDR = 2'd3;

	localparam logic [15:0] DEF_REFL_POLY = 16'h8408;
	localparam logic [15:0] SKIP_CRC_POLY = 16'h1021;
	localparam logic [31:0] DEF_SKIP_ADDR = 32'h0000_0046;
	localparam logic [31:0] SKIP_DISABLED = 32'hFFFF_FFFF;
	localparam logic [15:0] ALL_ONES_16   = 16'hFFFF;

	localparam logic [2:0]  RST_MODE      = MODE_CRC_REFL;
	localparam logic [15:0] RST_CRC_POLY  = 16'h8408;
	localparam logic        RST_LE_WORDS  = 1'b0;
	localparam logic [31:0] RST_SKIP_ADDR = 32'd70;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] crc_polynomial;
		logic        little_endian_words;
		logic [31:0] skip_address;
	} cfg_t;

	typedef struct packed {
		logic [31:0] acc;
		logic [31:0] idx;
		logic [7:0]  held;
	} st_t;

	// LSB-first CRC-16, one byte
	function automatic logic [15:0] crc_refl_byte(input logic [15:0] crc_in,
			input logic [7:0] b, input logic [15:0] poly);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ poly;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

	// MSB-first CRC-16 with fixed polynomial, one byte
	function automatic logic [15:0] crc_msb_byte(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] crc;
		crc = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (crc[15]) begin
				crc = (crc << 1) ^ SKIP_CRC_POLY;
			end else begin
				crc = crc << 1;
			end
		end
		return crc;
	endfunction

endpackage

// File: hdl/mmce_cfg.sv
// Configuration register file of the checksum engine.
`timescale 1ns / 1ps

module mmce_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata,
	output mmce_pkg::cfg_t      cfg
);

	mmce_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode                <= mmce_pkg::RST_MODE;
			cfg_q.crc_polynomial      <= mmce_pkg::RST_CRC_POLY;
			cfg_q.little_endian_words <= mmce_pkg::RST_LE_WORDS;
			cfg_q.skip_address        <= mmce_pkg::RST_SKIP_ADDR;
		end else if (cfg_we) begin
			case (cfg_addr)
				mmce_pkg::REG_MODE:      cfg_q.mode                <= cfg_wdata[2:0];
				mmce_pkg::REG_CRC_POLY:  cfg_q.crc_polynomial      <= cfg_wdata[15:0];
				mmce_pkg::REG_LE_WORDS:  cfg_q.little_endian_words <= cfg_wdata[0];
				mmce_pkg::REG_SKIP_ADDR: cfg_q.skip_address        <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/mmce_core.sv
// Per-byte update of the running checksum state and the result it would give.
`timescale 1ns / 1ps

module mmce_core (
	input  mmce_pkg::cfg_t cfg,
	input  mmce_pkg::st_t  st,
	input  logic [7:0]     data_byte,
	input  logic           last,
	output mmce_pkg::st_t  st_nxt,
	output logic [31:0]    result
);

	logic [31:0] acc0;
	logic [15:0] poly;
	logic [31:0] skip;
	logic [7:0]  crc_in_byte;
	logic [15:0] word;
	logic [15:0] sum16;
	logic [17:0] cnt_sum;
	logic [15:0] count;
	logic [15:0] low16;
	logic [15:0] crc16;

	always_comb begin
		// first byte of a block loads the start value of the current mode
		if (st.idx == 32'd0) begin
			acc0 = (cfg.mode == mmce_pkg::MODE_CRC_REFL) ? 32'h0000_FFFF : 32'd0;
		end else begin
			acc0 = st.acc;
		end

		poly = (cfg.crc_polynomial != 16'd0) ? cfg.crc_polynomial : mmce_pkg::DEF_REFL_POLY;
		skip = (cfg.skip_address != 32'd0) ? cfg.skip_address : mmce_pkg::DEF_SKIP_ADDR;

		crc_in_byte = data_byte;
		if (skip != mmce_pkg::SKIP_DISABLED &&
				(st.idx == skip || st.idx == skip + 32'd1)) begin
			crc_in_byte = 8'h00;
		end

		word = cfg.little_endian_words ? {data_byte, st.held} : {st.held, data_byte};
		// word count is (idx + 1) / 2 taken mod 2^16
		cnt_sum = {1'b0, st.idx[16:0]} + 18'd1;
		count   = cnt_sum[16:1];

		st_nxt = st;
		st_nxt.acc = acc0;
		result = 32'd0;
		sum16 = 16'd0;
		low16 = 16'd0;
		crc16 = 16'd0;

		case (cfg.mode)
			mmce_pkg::MODE_CRC_REFL: begin
				crc16 = mmce_pkg::crc_refl_byte(acc0[15:0], data_byte, poly);
				st_nxt.acc = {16'd0, crc16};
				result = {16'd0, ~crc16};
			end
			mmce_pkg::MODE_WORD_SUM: begin
				// a held first byte leaves the full accumulator untouched
				if (st.idx[0]) begin
					sum16 = acc0[15:0] + word;
					st_nxt.acc = {16'd0, sum16};
				end else begin
					sum16 = acc0[15:0];
					st_nxt.held = data_byte;
				end
				low16 = 16'd0 - count - sum16;
				result = {(sum16 == mmce_pkg::ALL_ONES_16) ? 16'd0 : sum16,
					(low16 == mmce_pkg::ALL_ONES_16) ? 16'd0 : low16};
			end
			mmce_pkg::MODE_BYTE_SUM: begin
				st_nxt.acc = acc0 + {24'd0, data_byte};
				result = st_nxt.acc;
			end
			mmce_pkg::MODE_CRC_SKIP: begin
				crc16 = mmce_pkg::crc_msb_byte(acc0[15:0], crc_in_byte);
				st_nxt.acc = {16'd0, crc16};
				result = {16'd0, crc16};
			end
			default: begin
				result = 32'd0;
			end
		endcase

		if (last) begin
			st_nxt.idx  = 32'd0;
			st_nxt.held = 8'h00;
		end else begin
			st_nxt.idx = st.idx + 32'd1;
		end
	end

endmodule

// File: hdl/multi_mode_checksum_engine_top.sv
// Top level of the multi-mode checksum engine: input stage, block state, result register.
//
//  channel   dir  tdata fields (low bit up)     tuser  tlast
//  s_axis    in   data_byte[7:0]                -      last
//  m_axis    out  checksum[31:0]                -      -
//  cfg       in   write enable, index [1:0], data [31:0]
//
// One byte per cycle while m_axis holds back no byte marked last; the accumulator update
// (eight unrolled CRC steps or one add) is combinational, which sets that rate.
// The checksum is registered in m_data_q as the byte marked last leaves the input stage.
// arst_n clears the block state to the start of a block and the configuration to defaults.
// A stalled m_axis holds back only a byte marked last; other bytes keep flowing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_mode_checksum_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] checksum
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	mmce_pkg::cfg_t cfg;
	mmce_pkg::st_t  st_q;
	mmce_pkg::st_t  st_nxt;
	logic [31:0]    result;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv;
	logic        m_valid_q;
	logic [31:0] m_data_q;

	mmce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mmce_core u_core (
		.cfg       (cfg),
		.st        (st_q),
		.data_byte (byte_s1),
		.last      (last_s1),
		.st_nxt    (st_nxt),
		.result    (result)
	);

	// a byte without last never waits on the output side
	assign adv = valid_s1 && (!last_s1 || !m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.acc  <= 32'h0000_FFFF;
			st_q.idx  <= 32'd0;
			st_q.held <= 8'h00;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			m_data_q <= result;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`ASSERT_CLK(a_idx_restart, clk, arst_n, (adv && last_s1) |=> (st_q.idx == 32'd0), "byte index not cleared after last byte")
	`ASSERT_CLK(a_held_clear, clk, arst_n, (adv && last_s1) |=> (st_q.held == 8'h00), "held byte not cleared after last byte")
	`ASSERT_CLK(a_out_source, clk, arst_n, $rose(m_valid_q) |-> $past(adv && last_s1), "result raised without a last byte")
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, adv && last_s1 && m_valid_q && !m_axis_tready, "pending result overwritten")

endmodule
